// ----- rtl/core/fdss_pkg.sv -----
// Shared constants and the digit-to-segment decoder for the seven-segment scan block.
package fdss_pkg;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned BCD_W      = 4;
  // A 16-bit value never has more than five decimal digits.
  localparam int unsigned MAX_DIGITS = 5;

  // v / 10 == (v * 52429) >> 19, exact for every 16-bit v.
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [SEG_W-1:0] SEG_OFF = '0;

  // Segment pattern, bit 0 = a ... bit 6 = g, 1 = lit.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [BCD_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = SEG_OFF;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/core/fdss_front.sv -----
// Front end: splits a value into BCD digits, one divide-by-ten step per cycle; the last waits on a full queue.
module fdss_front
  import fdss_pkg::*;
#(
  parameter int unsigned NUM_DIG = 4,
  parameter int unsigned IDX_W   = 2,
  parameter int unsigned ENTRY_W = NUM_DIG * BCD_W + IDX_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               q_push_o,
  input  logic               q_full_i,
  output logic [ENTRY_W-1:0] q_data_o
);

  localparam int unsigned PROD_W = VALUE_W + 17;

  logic                           busy_q, busy_d;
  logic [VALUE_W-1:0]             rem_q, rem_d;
  logic [IDX_W-1:0]               cnt_q, cnt_d;
  logic [IDX_W-1:0]               top_q, top_d;
  logic [NUM_DIG-1:0][BCD_W-1:0]  dig_q, dig_d;

  logic [PROD_W-1:0]              prod;
  logic [VALUE_W-1:0]             quot;
  logic [VALUE_W-1:0]             rmd;
  logic [BCD_W-1:0]               digit;
  logic                           last_step;
  logic                           accept;
  logic [NUM_DIG-1:0][BCD_W-1:0]  dig_out;
  logic [IDX_W-1:0]               top_out;

  assign prod  = PROD_W'(rem_q) * PROD_W'(DIV10_MUL);
  assign quot  = VALUE_W'(prod >> DIV10_SHIFT);
  assign rmd   = rem_q - ((quot << 3) + (quot << 1));
  assign digit = rmd[BCD_W-1:0];

  assign last_step = busy_q && (cnt_q == IDX_W'(NUM_DIG - 1));
  assign q_push_o  = last_step && !q_full_i;
  // A new value may enter in the cycle the current one leaves.
  assign full_o    = busy_q && !q_push_o;
  assign accept    = push_i && !full_o;

  // Entry with the digit of this cycle merged in.
  always_comb begin
    dig_out        = dig_q;
    dig_out[cnt_q] = digit;
    top_out        = (digit != '0) ? cnt_q : top_q;
  end

  assign q_data_o = {top_out, dig_out};

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    top_d  = top_q;
    dig_d  = dig_q;
    if (accept) begin
      busy_d = 1'b1;
      rem_d  = value_i;
      cnt_d  = '0;
      top_d  = '0;
    end else if (q_push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && !last_step) begin
      rem_d  = quot;
      cnt_d  = cnt_q + 1'b1;
      top_d  = top_out;
      dig_d  = dig_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    top_q <= top_d;
    dig_q <= dig_d;
  end

endmodule

// ----- rtl/core/fdss_fifo.sv -----
// Two-entry queue between the digit splitter and the scan sequencer.
module fdss_fifo #(
  parameter int unsigned WIDTH = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/fdss_back.sv -----
// Back end: walks the displayed digits of one entry and emits a closing blank result.
module fdss_back
  import fdss_pkg::*;
#(
  parameter int unsigned NUM_DIG = 4,
  parameter int unsigned IDX_W   = 2,
  parameter int unsigned ENTRY_W = NUM_DIG * BCD_W + IDX_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic [ENTRY_W-1:0] q_data_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [POS_W-1:0]   digit_position_o,
  output logic [SEG_W-1:0]   segments_o,
  output logic               blank_o,
  output logic               last_o
);

  logic                          act_q, act_d;
  logic                          closing_q, closing_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [NUM_DIG-1:0][BCD_W-1:0] dig_q, dig_d;

  logic                          out_vld_q, out_vld_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic [SEG_W-1:0]              seg_q, seg_d;
  logic                          blank_q, blank_d;
  logic                          last_q, last_d;

  logic                          can_emit;
  logic                          load_slot;
  logic [NUM_DIG-1:0][BCD_W-1:0] q_dig;
  logic [IDX_W-1:0]              q_top;
  logic [2:0]                    pos_wide;

  assign q_dig    = q_data_i[NUM_DIG*BCD_W-1:0];
  assign q_top    = q_data_i[ENTRY_W-1 -: IDX_W];
  assign pos_wide = 3'(idx_q);

  assign can_emit  = !out_vld_q || pop_i;
  // Next entry comes in while the closing result goes out.
  assign load_slot = !act_q || (can_emit && closing_q);
  assign q_pop_o   = load_slot && !q_empty_i;

  always_comb begin
    act_d     = act_q;
    closing_d = closing_q;
    idx_d     = idx_q;
    dig_d     = dig_q;
    out_vld_d = out_vld_q;
    pos_d     = pos_q;
    seg_d     = seg_q;
    blank_d   = blank_q;
    last_d    = last_q;

    if (can_emit) begin
      out_vld_d = act_q;
      if (closing_q) begin
        pos_d   = '0;
        seg_d   = SEG_OFF;
        blank_d = 1'b1;
        last_d  = 1'b1;
      end else begin
        pos_d   = pos_wide[POS_W-1:0];
        seg_d   = seg_pattern(dig_q[idx_q]);
        blank_d = 1'b0;
        last_d  = 1'b0;
      end
      if (act_q && !closing_q) begin
        if (idx_q == '0) begin
          closing_d = 1'b1;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end

    if (load_slot) begin
      act_d = !q_empty_i;
      if (!q_empty_i) begin
        closing_d = 1'b0;
        idx_d     = q_top;
        dig_d     = q_dig;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      closing_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      closing_q <= closing_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    dig_q   <= dig_d;
    pos_q   <= pos_d;
    seg_q   <= seg_d;
    blank_q <= blank_d;
    last_q  <= last_d;
  end

  assign empty_o          = !out_vld_q;
  assign digit_position_o = pos_q;
  assign segments_o       = seg_q;
  assign blank_o          = blank_q;
  assign last_o           = last_q;

endmodule

// ----- rtl/core/four_digit_seven_segment_scan_top.sv -----
// Top level of the seven-segment scan block: digit splitter, queue and scan sequencer.
//
//   channel | handshake      | payload
//   --------+----------------+--------------------------------------------------
//   input   | push_i, full_o | value_i[15:0]
//   result  | pop_i, empty_o | digit_position_o[1:0], segments_o[6:0], blank_o,
//           |                | last_o
//
// The front end splits each request with one multiply-by-reciprocal
// divide-by-ten step per digit, for N = min(DIGIT_COUNT, 5) digits. The back end
// emits top + 2 results per request (one per displayed digit plus the closing
// blank), up to N + 1. A two-entry queue lets the front split the next value
// while the back scans. Reset clears only control state; stalls on pop_i hold
// the output register.
module four_digit_seven_segment_scan_top
  import fdss_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [POS_W-1:0]   digit_position_o,
  output logic [SEG_W-1:0]   segments_o,
  output logic               blank_o,
  output logic               last_o
);

  // Digits above the fifth are always zero for a 16-bit value.
  localparam int unsigned NUM_DIG = (DIGIT_COUNT < MAX_DIGITS) ? DIGIT_COUNT : MAX_DIGITS;
  localparam int unsigned IDX_W   = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;
  // Queue entry: {index of top nonzero digit, BCD digits}.
  localparam int unsigned ENTRY_W = NUM_DIG * BCD_W + IDX_W;

  logic               f_push;
  logic               f_full;
  logic [ENTRY_W-1:0] f_data;
  logic               b_pop;
  logic               b_empty;
  logic [ENTRY_W-1:0] b_data;

  fdss_front #(
    .NUM_DIG (NUM_DIG),
    .IDX_W   (IDX_W),
    .ENTRY_W (ENTRY_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .value_i  (value_i),
    .q_push_o (f_push),
    .q_full_i (f_full),
    .q_data_o (f_data)
  );

  fdss_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .full_o  (f_full),
    .data_i  (f_data),
    .pop_i   (b_pop),
    .empty_o (b_empty),
    .data_o  (b_data)
  );

  fdss_back #(
    .NUM_DIG (NUM_DIG),
    .IDX_W   (IDX_W),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (b_empty),
    .q_pop_o          (b_pop),
    .q_data_i         (b_data),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .digit_position_o (digit_position_o),
    .segments_o       (segments_o),
    .blank_o          (blank_o),
    .last_o           (last_o)
  );

endmodule

// ----- dv/four_digit_seven_segment_scan_top_test.sv -----
// Self-checking testbench for the four-digit seven-segment scan block.
module four_digit_seven_segment_scan_top_test
  import fdss_pkg::*;
;

  localparam int unsigned DIGITS       = 4;
  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RANDOM_ITEMS = 106;
  // Stretch of random requests where neither side idles.
  localparam int unsigned CALM_FIRST   = 40;
  localparam int unsigned CALM_LAST    = 74;
  localparam int unsigned IDLE_PCT     = 23;
  // Idle time after the last expected result, watching for stray results.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned REPORT_MAX   = 10;

  // One displayed digit, or the closing blank that ends a request.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [SEG_W-1:0] seg;
    logic             blank;
    logic             last;
  } scan_result_t;

  // A directed row: the value plus, for the obvious cases, the results typed
  // in by hand (n_typed = 0 means the predictor supplies them).
  typedef struct packed {
    logic [VALUE_W-1:0]                  value;
    logic [2:0]                          n_typed;
    scan_result_t [0:MAX_DIGITS-1]       typed;
  } stim_row_t;

  function automatic scan_result_t lit(input int unsigned p, input logic [SEG_W-1:0] s);
    return '{pos: POS_W'(p), seg: s, blank: 1'b0, last: 1'b0};
  endfunction

  localparam scan_result_t NONE  = '0;
  localparam scan_result_t CLOSE = '{pos: '0, seg: SEG_OFF, blank: 1'b1, last: 1'b1};

  // Glyphs for 0..9, bit 0 = segment a.
  localparam logic [SEG_W-1:0] GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  localparam int unsigned N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // zero shows a single 0 on the units digit
    '{16'd0,     3'd2, {lit(0, 7'h3F), CLOSE, NONE, NONE, NONE}},
    // all ones: 65535 mod 10000 = 5535
    '{16'hFFFF,  3'd5, {lit(3, 7'h6D), lit(2, 7'h6D), lit(1, 7'h4F), lit(0, 7'h6D), CLOSE}},
    '{16'd1,     3'd2, {lit(0, 7'h06), CLOSE, NONE, NONE, NONE}},
    '{16'd9999,  3'd5, {lit(3, 7'h6F), lit(2, 7'h6F), lit(1, 7'h6F), lit(0, 7'h6F), CLOSE}},
    // fifth decimal digit dropped, leaves zero
    '{16'd10000, 3'd2, {lit(0, 7'h3F), CLOSE, NONE, NONE, NONE}},
    '{16'd60000, 3'd0, '0},
    '{16'd10001, 3'd0, '0},
    '{16'd9,     3'd0, '0},
    '{16'd10,    3'd0, '0},
    '{16'd100,   3'd0, '0},
    '{16'd1000,  3'd0, '0},
    // zeros inside the number stay lit
    '{16'd1010,  3'd0, '0},
    '{16'd8008,  3'd0, '0},
    '{16'd50505, 3'd0, '0},
    '{16'd1234,  3'd0, '0},
    '{16'd5678,  3'd0, '0},
    '{16'd20000, 3'd0, '0},
    '{16'd65530, 3'd0, '0},
    '{16'h5555,  3'd0, '0},
    '{16'hAAAA,  3'd0, '0},
    '{16'd9990,  3'd0, '0},
    '{16'd7,     3'd0, '0},
    '{16'd42,    3'd0, '0},
    '{16'd10009, 3'd0, '0}
  };

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               push_i  = 1'b0;
  logic [VALUE_W-1:0] value_i = '0;
  logic               pop_i   = 1'b0;
  logic               full_o;
  logic               empty_o;
  logic [POS_W-1:0]   digit_position_o;
  logic [SEG_W-1:0]   segments_o;
  logic               blank_o;
  logic               last_o;

  logic               calm = 1'b0;
  int unsigned        cycles = 0;
  int unsigned        scan_faults = 0;
  scan_result_t       display_due [$];

  four_digit_seven_segment_scan_top #(
    .DIGIT_COUNT(DIGITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .value_i         (value_i),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .digit_position_o(digit_position_o),
    .segments_o      (segments_o),
    .blank_o         (blank_o),
    .last_o          (last_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[four_digit_seven_segment_scan_top] ERROR");
      $finish;
    end
  end

  // Split the low decimal digits, drop leading zeros, queue one result per
  // shown digit (most significant first) and then the closing blank.
  function automatic void predict_display(input logic [VALUE_W-1:0] v);
    int unsigned rest;
    int unsigned lead;
    logic [3:0]  bcd [DIGITS];
    rest = v;
    lead = 0;
    for (int i = 0; i < DIGITS; i++) begin
      bcd[i] = 4'(rest % 10);
      rest   = rest / 10;
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 0) lead = i;
    end
    for (int i = lead; i >= 0; i--) begin
      display_due.push_back(lit(i, GLYPH[bcd[i]]));
    end
    display_due.push_back(CLOSE);
  endfunction

  // Offer one request; expectations are queued at the edge that accepts it.
  // push_i is left high on return so back-to-back requests never see a
  // lower-and-raise within one time step.
  task automatic send_value(input stim_row_t row);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i  <= 1'b1;
    value_i <= row.value;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    if (row.n_typed != 0) begin
      for (int j = 0; j < row.n_typed; j++) display_due.push_back(row.typed[j]);
    end else begin
      predict_display(row.value);
    end
  endtask

  function automatic void note_fault(input scan_result_t want, input scan_result_t got,
                                     input bit orphan);
    if (scan_faults < REPORT_MAX) begin
      if (orphan)
        $display("unexpected result: pos %0d seg %02h blank %b last %b",
                 got.pos, got.seg, got.blank, got.last);
      else
        $display("mismatch: pos %0d/%0d seg %02h/%02h blank %b/%b last %b/%b (exp/act)",
                 want.pos, got.pos, want.seg, got.seg, want.blank, got.blank,
                 want.last, got.last);
    end
    scan_faults++;
  endfunction

  // Result consumer: random stalls except inside the calm stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      pop_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Checker: every popped result against the oldest pending expectation.
  always @(posedge clk_i) begin : check_display
    scan_result_t got;
    scan_result_t want;
    if (rst_ni && pop_i && !empty_o) begin
      got = '{pos: digit_position_o, seg: segments_o, blank: blank_o, last: last_o};
      if (display_due.size() == 0) begin
        note_fault(NONE, got, 1'b1);
      end else begin
        want = display_due.pop_front();
        if (got.pos !== want.pos || got.seg !== want.seg ||
            got.blank !== want.blank || got.last !== want.last) begin
          note_fault(want, got, 1'b0);
        end
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] v;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners first.
    for (int r = 0; r < N_DIRECTED; r++) send_value(DIRECTED[r]);

    // Random part: a mix of short numbers, multiples of 10000 (shown as 0),
    // numbers with inner zeros, values near the top and full-range values.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm <= (k >= CALM_FIRST && k <= CALM_LAST);
      case ($urandom_range(0, 5))
        0:       v = VALUE_W'($urandom_range(0, 99));
        1:       v = VALUE_W'(10000 * $urandom_range(0, 6));
        2:       v = VALUE_W'($urandom_range(0, 9) * 1000 + $urandom_range(0, 9));
        3:       v = 16'hFFFF - VALUE_W'($urandom_range(0, 15));
        default: v = VALUE_W'($urandom_range(0, 65535));
      endcase
      send_value('{value: v, n_typed: 3'd0, typed: '0});
    end
    push_i <= 1'b0;

    // Let every pending result come out, then watch for strays.
    while (display_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (display_due.size() != 0) scan_faults++;

    if (scan_faults == 0) begin
      $display("[four_digit_seven_segment_scan_top] OK");
    end else begin
      $display("[four_digit_seven_segment_scan_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fdss_pkg.sv
rtl/core/fdss_front.sv
rtl/core/fdss_fifo.sv
rtl/core/fdss_back.sv
rtl/core/four_digit_seven_segment_scan_top.sv
dv/four_digit_seven_segment_scan_top_test.sv
